// ===== sv/windowed_bandwidth_meter_core_assert.svh =====
// assertion macros for the windowed bandwidth meter
// expects i_clk and i_rst_n in the scope that uses them
`ifndef WINDOWED_BANDWIDTH_METER_CORE_ASSERT_SVH
`define WINDOWED_BANDWIDTH_METER_CORE_ASSERT_SVH

// same-cycle implication
`define WBM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WBM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/wbm_pkg.sv =====
// shared types and constants of the windowed bandwidth meter
// no dependencies
package wbm_pkg;

    localparam int MAX_BUCKETS = 64;
    localparam int IDX_W       = $clog2(MAX_BUCKETS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int TIME_W      = 48;
    localparam int BYTES_W     = 40;
    localparam int BC_W        = 24;
    localparam int RATE_W      = 48;
    localparam int WS_W        = 6;
    localparam int IV_W        = 14;
    localparam int WMS_W       = 16;
    localparam int SUM_W       = BYTES_W + IDX_W;
    localparam int DVD_W       = 64;
    localparam int DVS_W       = 48;
    localparam int RAM_W       = TIME_W + BYTES_W;

    localparam logic [WS_W-1:0]  WS_RESET    = WS_W'(10);
    localparam logic [IV_W-1:0]  IV_DEFAULT  = IV_W'(250);
    localparam logic [WMS_W-1:0] MS_PER_SEC  = WMS_W'(1000);

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_AVG  = 2'd1,
        OP_PEAK = 2'd2
    } t_opcode;

    typedef enum logic {
        CFG_WINDOW   = 1'b0,
        CFG_INTERVAL = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DS_N,
        DS_Q,
        DS_K,
        DS_RATE
    } t_div_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NSTART,
        S_DIVN,
        S_DIVQ,
        S_KSTART,
        S_DIVK,
        S_ADD_RD,
        S_ADD_WR,
        S_WINIT,
        S_WALK,
        S_RSTART,
        S_DIVR
    } t_state;

    typedef struct packed {
        logic     capture;
        logic     div_start;
        t_div_sel div_sel;
        logic     add_rd;
        logic     add_wr;
        logic     walk_init;
        logic     walk_en;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       div_done;
        logic       walk_done;
    } t_status;

endpackage

// ===== sv/wbm_ram.sv =====
// generic single-write, single-read ram with registered read
// no dependencies
module wbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/wbm_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on wbm_pkg
module wbm_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [wbm_pkg::DVD_W-1:0] i_dividend,
    input  logic [wbm_pkg::DVS_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [wbm_pkg::DVD_W-1:0] o_quot,
    output logic [wbm_pkg::DVS_W-1:0] o_rem
);
    import wbm_pkg::*;

    localparam int STEP_W = $clog2(DVD_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [DVD_W-1:0]  r_quot, n_quot;
    logic [DVS_W:0]    r_rem,  n_rem;
    logic [DVS_W-1:0]  r_dvs,  n_dvs;
    logic [DVS_W:0]    trial;
    logic              fits;

    always_comb begin
        trial  = {r_rem[DVS_W-1:0], r_quot[DVD_W-1]};
        fits   = trial >= {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_quot = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem  = fits ? trial - {1'b0, r_dvs} : trial;
            n_quot = {r_quot[DVD_W-2:0], fits};
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(DVD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem[DVS_W-1:0];

endmodule

// ===== sv/wbm_ctrl.sv =====
// sequencer of the meter: divides, bucket update and bucket walk
// depends on wbm_pkg
module wbm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  wbm_pkg::t_status i_status,
    output wbm_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    import wbm_pkg::*;

    t_state r_state, n_state;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.div_sel = DS_N;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.capture = 1'b1;
                    n_state = S_NSTART;
                end
            end
            S_NSTART: begin
                if (i_status.op == OP_ADD || i_status.op == OP_AVG ||
                    i_status.op == OP_PEAK) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DS_N;
                    n_state = S_DIVN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIVN: begin
                if (i_status.div_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DS_Q;
                    n_state = S_DIVQ;
                end
            end
            S_DIVQ: begin
                if (i_status.div_done) begin
                    n_state = S_KSTART;
                end
            end
            S_KSTART: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DS_K;
                n_state = S_DIVK;
            end
            S_DIVK: begin
                if (i_status.div_done) begin
                    n_state = (i_status.op == OP_ADD) ? S_ADD_RD : S_WINIT;
                end
            end
            S_ADD_RD: begin
                cmd.add_rd = 1'b1;
                n_state = S_ADD_WR;
            end
            S_ADD_WR: begin
                cmd.add_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_WINIT: begin
                cmd.walk_init = 1'b1;
                n_state = S_WALK;
            end
            S_WALK: begin
                cmd.walk_en = 1'b1;
                if (i_status.walk_done) begin
                    n_state = S_RSTART;
                end
            end
            S_RSTART: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DS_RATE;
                n_state = S_DIVR;
            end
            S_DIVR: begin
                if (i_status.div_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== sv/wbm_datapath.sv =====
// datapath of the meter: config, bucket store, walk accumulators, divider
// depends on wbm_pkg, wbm_ram, wbm_div and the assertion header
`include "windowed_bandwidth_meter_core_assert.svh"

module wbm_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [wbm_pkg::IV_W-1:0]  i_cfg_data,
    input  logic [1:0]                i_opcode,
    input  logic [wbm_pkg::TIME_W-1:0] i_now_ms,
    input  logic [wbm_pkg::BC_W-1:0]  i_byte_count,
    input  wbm_pkg::t_cmd             i_cmd,
    output wbm_pkg::t_status          o_status,
    output logic                      o_valid,
    output logic [wbm_pkg::RATE_W-1:0] o_rate_bps,
    output logic                      o_was_peak
);
    import wbm_pkg::*;

    // config
    logic [WS_W-1:0]  r_ws;
    logic [IV_W-1:0]  r_iv;
    logic [IV_W-1:0]  iv_eff;
    logic [WMS_W-1:0] win_ms;

    // item and derived values
    logic [1:0]        r_op;
    logic [TIME_W-1:0] r_now;
    logic [BC_W-1:0]   r_bc;
    logic [CNT_W-1:0]  r_n;
    logic [TIME_W-1:0] r_q;
    logic [IV_W-1:0]   r_r;
    logic [IDX_W-1:0]  r_k;
    t_div_sel          r_div_sel;

    // walk
    logic [IDX_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_acc_vld;
    logic [IDX_W-1:0]  r_acc_idx;
    logic [SUM_W-1:0]  r_sum;
    logic [TIME_W-1:0] r_oldest;
    logic [BYTES_W-1:0] r_maxb;
    logic [MAX_BUCKETS-1:0] r_slot_vld;

    // output
    logic              r_o_valid;
    logic [RATE_W-1:0] r_o_rate;
    logic              r_o_peak;

    // divider
    logic [DVD_W-1:0] div_dvd;
    logic [DVS_W-1:0] div_dvs;
    logic             div_done;
    logic [DVD_W-1:0] div_quot;
    logic [DVS_W-1:0] div_rem;

    // ram
    logic               ram_we;
    logic [IDX_W-1:0]   ram_raddr;
    logic [RAM_W-1:0]   ram_wdata;
    logic [RAM_W-1:0]   ram_rdata;
    logic [TIME_W-1:0]  rd_start;
    logic [BYTES_W-1:0] rd_bytes;

    logic [TIME_W-1:0]  age;
    logic               not_before;
    logic               rd_vld;
    logic               in_win;
    logic               complete;
    logic [TIME_W-1:0]  aligned;
    logic               stale;
    logic [BYTES_W:0]   bsum;
    logic [BYTES_W-1:0] new_bytes;
    logic [TIME_W-1:0]  elapsed;
    logic [DVD_W-1:0]   sum_x;
    logic [DVD_W-1:0]   max_x;
    logic [CNT_W-1:0]   n_clamp;
    logic [IDX_W-1:0]   idx_last;

    assign iv_eff = (r_iv == '0) ? IV_DEFAULT : r_iv;
    assign win_ms = WMS_W'(r_ws) * MS_PER_SEC;

    assign rd_start   = ram_rdata[RAM_W-1:BYTES_W];
    assign rd_bytes   = ram_rdata[BYTES_W-1:0];
    assign age        = r_now - rd_start;
    assign not_before = r_now >= rd_start;
    assign aligned    = r_now - TIME_W'(r_r);
    assign elapsed    = r_now - r_oldest;
    assign idx_last   = IDX_W'(r_n - 1'b1);

    always_comb begin
        rd_vld   = r_slot_vld[r_acc_idx];
        in_win   = rd_vld && (!not_before || age <= TIME_W'(win_ms));
        complete = rd_vld && not_before && age <= TIME_W'(win_ms) &&
                   age >= TIME_W'(iv_eff);
        // add path reads at r_k
        stale    = !r_slot_vld[r_k] || (not_before && age > TIME_W'(win_ms));
        bsum     = {1'b0, rd_bytes} + (BYTES_W + 1)'(r_bc);
        if (stale || rd_start != aligned) begin
            new_bytes = BYTES_W'(r_bc);
        end else if (bsum[BYTES_W]) begin
            new_bytes = '1;
        end else begin
            new_bytes = bsum[BYTES_W-1:0];
        end
        // times 8000 as shifts: 8192 - 128 - 64
        sum_x = (DVD_W'(r_sum) << 13) - (DVD_W'(r_sum) << 7) - (DVD_W'(r_sum) << 6);
        max_x = (DVD_W'(r_maxb) << 13) - (DVD_W'(r_maxb) << 7) - (DVD_W'(r_maxb) << 6);
        if (div_quot == '0) begin
            n_clamp = CNT_W'(1);
        end else if (div_quot > DVD_W'(MAX_BUCKETS)) begin
            n_clamp = CNT_W'(MAX_BUCKETS);
        end else begin
            n_clamp = div_quot[CNT_W-1:0];
        end
        unique case (i_cmd.div_sel)
            DS_N: begin
                div_dvd = DVD_W'(win_ms);
                div_dvs = DVS_W'(iv_eff);
            end
            DS_Q: begin
                div_dvd = DVD_W'(r_now);
                div_dvs = DVS_W'(iv_eff);
            end
            DS_K: begin
                div_dvd = DVD_W'(r_q);
                div_dvs = DVS_W'(r_n);
            end
            DS_RATE: begin
                if (r_op == OP_AVG) begin
                    div_dvd = sum_x;
                    div_dvs = elapsed;
                end else begin
                    div_dvd = max_x;
                    div_dvs = DVS_W'(iv_eff);
                end
            end
            default: begin
                div_dvd = '0;
                div_dvs = '0;
            end
        endcase
    end

    assign ram_we    = i_cmd.add_wr;
    assign ram_raddr = i_cmd.walk_en ? r_idx : r_k;
    assign ram_wdata = {aligned, new_bytes};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws       <= WS_RESET;
            r_iv       <= IV_DEFAULT;
            r_slot_vld <= '0;
            r_acc_vld  <= 1'b0;
            r_cnt      <= '0;
            r_o_valid  <= 1'b0;
            r_div_sel  <= DS_N;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_WINDOW:   r_ws <= i_cfg_data[WS_W-1:0];
                    CFG_INTERVAL: r_iv <= i_cfg_data;
                    default:      r_iv <= r_iv;
                endcase
            end
            if (i_cmd.div_start) begin
                r_div_sel <= i_cmd.div_sel;
            end
            if (i_cmd.add_wr) begin
                r_slot_vld[r_k] <= 1'b1;
            end
            r_acc_vld <= 1'b0;
            if (i_cmd.walk_init) begin
                r_cnt <= (r_op == OP_AVG) ? (r_n >> 2) : r_n;
            end else if (i_cmd.walk_en && r_cnt != '0) begin
                r_cnt     <= r_cnt - 1'b1;
                r_acc_vld <= 1'b1;
            end
            r_o_valid <= div_done && r_div_sel == DS_RATE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_now <= i_now_ms;
            r_bc  <= i_byte_count;
        end
        if (div_done) begin
            unique case (r_div_sel)
                DS_N: r_n <= n_clamp;
                DS_Q: begin
                    r_q <= div_quot[TIME_W-1:0];
                    r_r <= div_rem[IV_W-1:0];
                end
                DS_K: r_k <= div_rem[IDX_W-1:0];
                DS_RATE: begin
                    if (r_op == OP_AVG && elapsed == '0) begin
                        r_o_rate <= '0;
                    end else if (div_quot > DVD_W'({RATE_W{1'b1}})) begin
                        r_o_rate <= '1;
                    end else begin
                        r_o_rate <= div_quot[RATE_W-1:0];
                    end
                    r_o_peak <= (r_op == OP_PEAK);
                end
                default: r_n <= r_n;
            endcase
        end
        if (i_cmd.walk_init) begin
            r_idx    <= (r_op == OP_AVG) ? r_k : '0;
            r_sum    <= '0;
            r_oldest <= r_now;
            r_maxb   <= '0;
        end else begin
            if (i_cmd.walk_en && r_cnt != '0) begin
                r_acc_idx <= r_idx;
                if (r_op == OP_AVG) begin
                    r_idx <= (r_idx == '0) ? idx_last : r_idx - 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (r_acc_vld) begin
                if (r_op == OP_AVG) begin
                    if (complete) begin
                        r_sum <= r_sum + SUM_W'(rd_bytes);
                        if (rd_start < r_oldest) begin
                            r_oldest <= rd_start;
                        end
                    end
                end else if (in_win && rd_bytes > r_maxb) begin
                    r_maxb <= rd_bytes;
                end
            end
        end
    end

    wbm_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_BUCKETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_k),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    wbm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign o_status.op        = r_op;
    assign o_status.div_done  = div_done;
    assign o_status.walk_done = (r_cnt == '0) && !r_acc_vld;

    assign o_valid    = r_o_valid;
    assign o_rate_bps = r_o_rate;
    assign o_was_peak = r_o_peak;

    // walk never reads past the live bucket count
    `WBM_ASSERT_IMP(a_walk_idx, r_acc_vld, {1'b0, r_acc_idx} < r_n, "walk index out of range")
    // bucket update stays inside the ring
    `WBM_ASSERT_IMP(a_add_idx, i_cmd.add_wr, {1'b0, r_k} < r_n, "add index out of range")
    // results come as isolated one-cycle strobes
    `WBM_ASSERT_NXT(a_strobe, r_o_valid, !r_o_valid, "result strobe held")
    // a result only follows a rate divide
    `WBM_ASSERT_NXT(a_rate_src, div_done && r_div_sel != DS_RATE, !r_o_valid,
        "result without rate divide")

endmodule

// ===== sv/windowed_bandwidth_meter_core.sv =====
// windowed bandwidth meter, top level
// depends on wbm_pkg, wbm_ctrl and wbm_datapath
//
// usage:
//   items enter on start/busy: an item is taken when start is high and busy
//   is low. opcode 0 credits byte_count to the bucket of now_ms, 1 asks for
//   the average rate, 2 for the peak rate, 3 is dropped with no result.
//   each query gives one result on o_rate_bps/o_was_peak, marked by o_valid
//   for a single cycle; the receiver cannot hold it off.
//   timing is set by one shared radix-2 divider that works out 64 quotient
//   bits per divide. busy stays high after acceptance for
//     add item     : 3 divides
//     average query: 4 divides + N/4 bucket reads
//     peak query   : 4 divides + N bucket reads
//   N is the bucket count; the walk reads one bucket per cycle from the
//   bucket ram. the result strobe comes in the first cycle busy is low.
//   config writes (i_cfg_we, i_cfg_idx, i_cfg_data) land at once; write
//   only while busy is low.
//   reset: registers return to 10 s window and 250 ms interval, all
//   bucket valid bits clear together, no sweep is needed.
module windowed_bandwidth_meter_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_opcode,
    input  logic [wbm_pkg::TIME_W-1:0]  i_now_ms,
    input  logic [wbm_pkg::BC_W-1:0]    i_byte_count,
    output logic                        o_valid,
    output logic [wbm_pkg::RATE_W-1:0]  o_rate_bps,
    output logic                        o_was_peak,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [wbm_pkg::IV_W-1:0]    i_cfg_data
);
    import wbm_pkg::*;

    t_cmd    cmd;
    t_status status;

    wbm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    wbm_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_opcode     (i_opcode),
        .i_now_ms     (i_now_ms),
        .i_byte_count (i_byte_count),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_valid      (o_valid),
        .o_rate_bps   (o_rate_bps),
        .o_was_peak   (o_was_peak)
    );

endmodule

// ===== tb/tb_windowed_bandwidth_meter_core.sv =====
// self-checking testbench for windowed_bandwidth_meter_core
// depends on wbm_pkg and the core; holds its own bucket predictor
`timescale 1ns / 100ps

module tb_windowed_bandwidth_meter_core;
    import wbm_pkg::*;

    localparam int  CLK_HALF   = 4;
    localparam longint LIMIT_CYC = 4000000;
    localparam int  DRAIN_CYC  = 600;
    localparam logic [1:0] OP_BAD = 2'd3;
    localparam logic [47:0] RATE_SAT = 48'hFFFF_FFFF_FFFF;
    localparam logic [39:0] BYTES_SAT = 40'hFF_FFFF_FFFF;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_opcode;
    logic [47:0] i_now_ms;
    logic [23:0] i_byte_count;
    logic        o_valid;
    logic [47:0] o_rate_bps;
    logic        o_was_peak;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [13:0] i_cfg_data;

    windowed_bandwidth_meter_core i_dut (.*);

    // predictor state
    logic [39:0] pm_bytes [MAX_BUCKETS];
    logic [47:0] pm_start [MAX_BUCKETS];
    logic        pm_valid [MAX_BUCKETS];
    logic [5:0]  pm_window_s;
    logic [13:0] pm_interval;

    typedef struct {
        logic [47:0] rate;
        logic        peak;
    } t_rate_result;

    t_rate_result expected_rates[$];
    int     mismatches;
    bit     idle_on;
    longint cycle_cnt;
    logic [47:0] clock_ms;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > LIMIT_CYC) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic longint unsigned eff_iv();
        return (pm_interval == 0) ? 64'd250 : 64'(pm_interval);
    endfunction

    function automatic longint unsigned win_ms();
        return 64'(pm_window_s) * 1000;
    endfunction

    function automatic longint unsigned nbuckets();
        longint unsigned n;
        n = win_ms() / eff_iv();
        if (n < 1) n = 1;
        if (n > MAX_BUCKETS) n = MAX_BUCKETS;
        return n;
    endfunction

    function automatic bit live_bucket(int k, longint unsigned now);
        if (!pm_valid[k]) return 1'b0;
        if (now < pm_start[k]) return 1'b1;
        return (now - pm_start[k]) <= win_ms();
    endfunction

    function automatic logic [47:0] clip_rate(logic [127:0] r);
        return (r > RATE_SAT) ? RATE_SAT : r[47:0];
    endfunction

    task automatic credit_bytes(longint unsigned now, longint unsigned nb);
        longint unsigned iv, al;
        logic [63:0] t;
        int k;
        iv = eff_iv();
        k  = int'((now / iv) % nbuckets());
        al = now - (now % iv);
        if (!pm_valid[k] || (now >= pm_start[k] && now - pm_start[k] > win_ms())) begin
            pm_bytes[k] = '0;
            pm_start[k] = al[47:0];
        end
        pm_valid[k] = 1'b1;
        if (pm_start[k] != al) begin
            pm_start[k] = al[47:0];
            pm_bytes[k] = nb[39:0];
        end else begin
            t = 64'(pm_bytes[k]) + nb;
            pm_bytes[k] = (t > BYTES_SAT) ? BYTES_SAT : t[39:0];
        end
    endtask

    function automatic logic [47:0] average_rate(longint unsigned now);
        longint unsigned iv, n, cur, oldest;
        logic [127:0] total;
        int k;
        iv = eff_iv();
        n = nbuckets();
        cur = (now / iv) % n;
        total = '0;
        oldest = now;
        for (longint unsigned i = 0; i < n / 4; i++) begin
            k = int'((cur + n - i) % n);
            if (live_bucket(k, now) && now >= pm_start[k] && now - pm_start[k] >= iv) begin
                total += 128'(pm_bytes[k]);
                if (pm_start[k] < oldest) oldest = 64'(pm_start[k]);
            end
        end
        if (now <= oldest) return '0;
        return clip_rate((total * 8000) / (now - oldest));
    endfunction

    function automatic logic [47:0] peak_rate(longint unsigned now);
        logic [127:0] best, r;
        best = '0;
        for (int k = 0; k < int'(nbuckets()); k++) begin
            if (live_bucket(k, now)) begin
                r = (128'(pm_bytes[k]) * 8000) / eff_iv();
                if (r > best) best = r;
            end
        end
        return clip_rate(best);
    endfunction

    // rising-edge sampling of results
    initial begin
        t_rate_result e;
        mismatches = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid) begin
                if (expected_rates.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result rate=%0d peak=%0b", o_rate_bps, o_was_peak);
                end else begin
                    e = expected_rates.pop_front();
                    if (e.rate !== o_rate_bps || e.peak !== o_was_peak) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp rate=%0d peak=%0b got rate=%0d peak=%0b",
                                     e.rate, e.peak, o_rate_bps, o_was_peak);
                    end
                end
            end
        end
    end

    task automatic send_item(logic [1:0] op, logic [47:0] now, logic [23:0] nb);
        t_rate_result r;
        if (idle_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        else
            @(negedge i_clk);
        start        <= 1'b1;
        i_opcode     <= op;
        i_now_ms     <= now;
        i_byte_count <= nb;
        do @(posedge i_clk); while (busy);
        case (op)
            OP_ADD:  credit_bytes(now, nb);
            OP_AVG:  begin r.rate = average_rate(now); r.peak = 1'b0; expected_rates.push_back(r); end
            OP_PEAK: begin r.rate = peak_rate(now); r.peak = 1'b1; expected_rates.push_back(r); end
            default: ;
        endcase
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic drain();
        while (expected_rates.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [13:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_WINDOW) pm_window_s = val[5:0];
        else pm_interval = val;
        @(negedge i_clk);
    endtask

    task automatic set_config(logic [5:0] ws, logic [13:0] iv);
        drain();
        write_reg(CFG_WINDOW, 14'(ws));
        write_reg(CFG_INTERVAL, iv);
    endtask

    task automatic test_directed();
        send_item(OP_AVG, 48'd0, 24'd0);
        send_item(OP_PEAK, 48'd0, 24'd0);
        send_item(OP_ADD, 48'd10, 24'hFFFFFF);
        send_item(OP_ADD, 48'd100, 24'hFFFFFF);
        send_item(OP_BAD, 48'd120, 24'hABCDEF);
        send_item(OP_ADD, 48'd300, 24'd1000);
        send_item(OP_ADD, 48'd200, 24'd7);          // time going backwards
        send_item(OP_AVG, 48'd150, 24'd0);
        send_item(OP_AVG, 48'd2600, 24'd0);
        send_item(OP_PEAK, 48'd2600, 24'd0);
        send_item(OP_ADD, 48'd20000, 24'd5);        // stale bucket restart
        send_item(OP_PEAK, 48'd20100, 24'd0);
        // repeated full-size adds into one bucket, then rate queries, with 1 ms buckets
        set_config(6'd1, 14'd1);
        for (int i = 0; i < 4; i++) send_item(OP_ADD, 48'hFFFF_FFFF_FF00, 24'hFFFFFF);
        send_item(OP_PEAK, 48'hFFFF_FFFF_FF00, 24'd0);
        send_item(OP_AVG, 48'hFFFF_FFFF_FFFF, 24'd0);
        set_config(6'd0, 14'd0);                    // zero interval, zero window
        send_item(OP_ADD, 48'h8000_0000_0000, 24'h5A5A5A);
        send_item(OP_PEAK, 48'h8000_0000_0001, 24'd0);
        set_config(6'd63, 14'h3FFF);
        send_item(OP_ADD, 48'h8000_0001_0000, 24'd1);
        send_item(OP_AVG, 48'h8000_0002_0000, 24'd0);
    endtask

    task automatic test_random(int count, logic [5:0] ws, logic [13:0] iv);
        logic [1:0]  op;
        logic [47:0] t;
        int sel;
        set_config(ws, iv);
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 19);
            op = (sel < 12) ? OP_ADD : (sel < 15) ? OP_AVG : (sel < 19) ? OP_PEAK : OP_BAD;
            if ($urandom_range(0, 30) == 0)
                t = 48'({$urandom, $urandom});   // wild jump, either way
            else
                t = 48'(clock_ms + $urandom_range(0, 2 * int'(eff_iv())));
            clock_ms = t;
            send_item(op, t, ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 3000)));
            if (i == count / 2 && ws == 6'd10) drain();     // let results catch up once
        end
    endtask

    initial begin
        i_rst_n = 1'b0; start = 1'b0; i_opcode = OP_ADD; i_now_ms = '0; i_byte_count = '0;
        i_cfg_we = 1'b0; i_cfg_idx = CFG_WINDOW; i_cfg_data = '0;
        pm_window_s = 6'd10; pm_interval = 14'd250; clock_ms = '0; idle_on = 1'b1;
        for (int k = 0; k < MAX_BUCKETS; k++) begin
            pm_bytes[k] = '0; pm_start[k] = '0; pm_valid[k] = 1'b0;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(300, 6'd10, 14'd250);
        test_random(250, 6'd60, 14'd1);
        test_random(250, 6'd1, 14'd10000);
        test_random(250, 6'd3, 14'd17);
        test_random(150, 6'd0, 14'd0);
        idle_on = 1'b0;
        test_random(200, 6'd40, 14'd500);
        drain();
        if (mismatches == 0 && expected_rates.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
